// File: sv/cctr_pkg.sv
// ----------------------------------------------------------------------------
// cctr_pkg: shared types and constants of the C constant token recognizer
// Phase codes, flag positions, kind and suffix codes, the result record.
// ----------------------------------------------------------------------------
package cctr_pkg;

    localparam int unsigned MaxTokenLen = 255;

    // Scan phases, one-hot
    typedef enum logic [15:0] {
        PH_IDLE   = 16'h0001,
        PH_DONE   = 16'h0002,
        PH_CHL    = 16'h0004,
        PH_CHBODY = 16'h0008,
        PH_ZERO   = 16'h0010,
        PH_DEC    = 16'h0020,
        PH_HEX    = 16'h0040,
        PH_ZFLT   = 16'h0080,
        PH_FRAC   = 16'h0100,
        PH_EXPS   = 16'h0200,
        PH_EXPSG  = 16'h0400,
        PH_EXPD   = 16'h0800,
        PH_SU     = 16'h1000,
        PH_SUL    = 16'h2000,
        PH_SL     = 16'h4000,
        PH_SLL    = 16'h8000
    } t_phase;

    // Kind codes
    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_CHAR = 3'd1;
    localparam logic [2:0] K_DEC  = 3'd2;
    localparam logic [2:0] K_OCT  = 3'd3;
    localparam logic [2:0] K_HEX  = 3'd4;
    localparam logic [2:0] K_DFLT = 3'd5;
    localparam logic [2:0] K_HFLT = 3'd6;

    // Suffix codes
    localparam logic [3:0] S_INT    = 4'd0;
    localparam logic [3:0] S_UINT   = 4'd1;
    localparam logic [3:0] S_LONG   = 4'd2;
    localparam logic [3:0] S_ULONG  = 4'd3;
    localparam logic [3:0] S_LLONG  = 4'd4;
    localparam logic [3:0] S_ULLONG = 4'd5;
    localparam logic [3:0] S_WCHAR  = 4'd6;
    localparam logic [3:0] S_FLOAT  = 4'd7;
    localparam logic [3:0] S_DOUBLE = 4'd8;
    localparam logic [3:0] S_LDBL   = 4'd9;

    // Scan flag bits
    localparam int unsigned F_HEX = 0;
    localparam int unsigned F_WIDE = 1;
    localparam int unsigned F_MANT = 2;
    localparam int unsigned F_POINT = 3;
    localparam int unsigned F_SAT = 4;
    localparam int unsigned F_CONTENT = 5;
    localparam int unsigned F_OCT = 6;

    typedef struct packed {
        logic [7:0] len;
        logic [2:0] kind;
        logic [3:0] suf;
        logic       ld;
        logic       sat;
    } t_res;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] len;
        logic [7:0] digits;
        logic [6:0] flags;
        logic [7:0] sfc;
        logic       esc;
    } t_scan;

    function automatic logic [7:0] upc(input logic [7:0] c);
        upc = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        is_dig = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_hexd(input logic [7:0] c);
        is_hexd = is_dig(c) || (upc(c) >= 8'h41 && upc(c) <= 8'h46);
    endfunction

endpackage

// File: sv/cctr_step.sv
// ----------------------------------------------------------------------------
// cctr_step: one character step of the constant scanner
// Pure logic: current scan state and a character give the next state and
// at most one decided result.
// ----------------------------------------------------------------------------
module cctr_step (
    input  cctr_pkg::t_scan i_s,
    input  logic [7:0]      i_c,
    output cctr_pkg::t_scan o_s,
    output logic            o_emit,
    output cctr_pkg::t_res  o_res
);
    logic [7:0] u;
    logic       hex;

    always_comb begin
        u   = cctr_pkg::upc(i_c);
        hex = i_s.flags[cctr_pkg::F_HEX];
        o_s = i_s;
        o_emit = 1'b0;
        o_res  = '0;

        // Helper flow written out per phase; "consume" bumps length or sets SAT
        unique case (i_s.phase)
            cctr_pkg::PH_CHL: begin
                if (i_c == 8'h27) begin
                    consume();
                    o_s.phase = cctr_pkg::PH_CHBODY;
                end else reject();
            end
            cctr_pkg::PH_CHBODY: begin
                if (i_c == 8'h00 || i_c == 8'h0a) reject();
                else if (i_c == 8'h27 && !i_s.esc) begin
                    if (!i_s.flags[cctr_pkg::F_CONTENT]) reject();
                    else begin
                        consume();
                        tok(cctr_pkg::K_CHAR, i_s.flags[cctr_pkg::F_WIDE] ?
                            cctr_pkg::S_WCHAR : cctr_pkg::S_INT, 1'b0);
                    end
                end else begin
                    consume();
                    o_s.flags[cctr_pkg::F_CONTENT] = 1'b1;
                    o_s.esc = !i_s.esc && i_c == 8'h5c;
                end
            end
            cctr_pkg::PH_ZERO: begin
                if (i_c >= 8'h30 && i_c <= 8'h37) begin
                    consume();
                    cdig();
                end else if (u == 8'h58 && i_s.digits == 8'd1) begin
                    consume();
                    o_s.flags[cctr_pkg::F_HEX]  = 1'b1;
                    o_s.flags[cctr_pkg::F_MANT] = 1'b0;
                    o_s.digits = '0;
                    o_s.phase  = cctr_pkg::PH_HEX;
                end else if (i_c == 8'h38 || i_c == 8'h39) begin
                    consume();
                    o_s.phase = cctr_pkg::PH_ZFLT;
                end else if (i_c == 8'h2e) to_frac();
                else if (u == 8'h45) start_exp();
                else if (u == 8'h50) reject();
                else begin
                    o_s.flags[cctr_pkg::F_OCT] = 1'b1;
                    int_end();
                end
            end
            cctr_pkg::PH_DEC: begin
                if (cctr_pkg::is_dig(i_c)) begin
                    consume();
                    cdig();
                end else if (i_c == 8'h2e) to_frac();
                else if (u == 8'h45) start_exp();
                else if (u == 8'h50) reject();
                else int_end();
            end
            cctr_pkg::PH_HEX: begin
                if (cctr_pkg::is_hexd(i_c)) begin
                    consume();
                    cdig();
                    o_s.flags[cctr_pkg::F_MANT] = 1'b1;
                end else if (i_c == 8'h2e) to_frac();
                else if (u == 8'h50) start_exp();
                else int_end();
            end
            cctr_pkg::PH_ZFLT: begin
                if (cctr_pkg::is_dig(i_c)) consume();
                else if (i_c == 8'h2e) to_frac();
                else if (u == 8'h45) start_exp();
                else reject();
            end
            cctr_pkg::PH_FRAC: begin
                if (hex ? cctr_pkg::is_hexd(i_c) : cctr_pkg::is_dig(i_c)) begin
                    consume();
                    o_s.flags[cctr_pkg::F_MANT] = 1'b1;
                end else if (u == (hex ? 8'h50 : 8'h45)) start_exp();
                else if (!i_s.flags[cctr_pkg::F_MANT] || hex) reject();
                else float_end();
            end
            cctr_pkg::PH_EXPS: begin
                if (i_c == 8'h2b || i_c == 8'h2d) begin
                    consume();
                    o_s.phase = cctr_pkg::PH_EXPSG;
                end else if (cctr_pkg::is_dig(i_c)) begin
                    consume();
                    o_s.phase = cctr_pkg::PH_EXPD;
                end else reject();
            end
            cctr_pkg::PH_EXPSG: begin
                if (cctr_pkg::is_dig(i_c)) begin
                    consume();
                    o_s.phase = cctr_pkg::PH_EXPD;
                end else reject();
            end
            cctr_pkg::PH_EXPD: begin
                if (cctr_pkg::is_dig(i_c)) consume();
                else float_end();
            end
            cctr_pkg::PH_SU: begin
                if (u == 8'h4c) begin
                    consume();
                    o_s.sfc   = i_c;
                    o_s.phase = cctr_pkg::PH_SUL;
                end else int_done(cctr_pkg::S_UINT);
            end
            cctr_pkg::PH_SUL: begin
                if (i_c == i_s.sfc) begin
                    consume();
                    int_done(cctr_pkg::S_ULLONG);
                end else int_done(cctr_pkg::S_ULONG);
            end
            cctr_pkg::PH_SL: begin
                if (i_c == i_s.sfc) begin
                    consume();
                    o_s.phase = cctr_pkg::PH_SLL;
                end else if (u == 8'h55) begin
                    consume();
                    int_done(cctr_pkg::S_ULONG);
                end else int_done(cctr_pkg::S_LONG);
            end
            cctr_pkg::PH_SLL: begin
                if (u == 8'h55) begin
                    consume();
                    int_done(cctr_pkg::S_ULLONG);
                end else int_done(cctr_pkg::S_LLONG);
            end
            default: begin
            end
        endcase
    end

    // Step helpers; they act on o_s / o_res of the enclosing block
    function automatic void consume();
        if (o_s.len < 8'(cctr_pkg::MaxTokenLen)) o_s.len = o_s.len + 8'd1;
        else o_s.flags[cctr_pkg::F_SAT] = 1'b1;
    endfunction

    function automatic void cdig();
        if (o_s.digits != 8'hff) o_s.digits = o_s.digits + 8'd1;
    endfunction

    function automatic void reject();
        o_emit = 1'b1;
        o_res  = '0;
        o_s.phase = cctr_pkg::PH_DONE;
    endfunction

    function automatic void tok(input logic [2:0] k, input logic [3:0] s, input logic l);
        o_emit = 1'b1;
        o_res.len  = o_s.len;
        o_res.kind = k;
        o_res.suf  = s;
        o_res.ld   = l;
        o_res.sat  = o_s.flags[cctr_pkg::F_SAT];
        o_s.phase  = cctr_pkg::PH_DONE;
    endfunction

    function automatic void int_done(input logic [3:0] s);
        tok(o_s.flags[cctr_pkg::F_HEX] ? cctr_pkg::K_HEX :
            (o_s.flags[cctr_pkg::F_OCT] ? cctr_pkg::K_OCT : cctr_pkg::K_DEC),
            s, o_s.digits >= 8'd10);
    endfunction

    function automatic void int_end();
        if (o_s.flags[cctr_pkg::F_HEX] && o_s.digits == 8'd0) reject();
        else if (u == 8'h55) begin
            consume();
            o_s.phase = cctr_pkg::PH_SU;
        end else if (u == 8'h4c) begin
            consume();
            o_s.sfc   = i_c;
            o_s.phase = cctr_pkg::PH_SL;
        end else int_done(cctr_pkg::S_INT);
    endfunction

    function automatic void float_end();
        logic [2:0] k;
        k = o_s.flags[cctr_pkg::F_HEX] ? cctr_pkg::K_HFLT : cctr_pkg::K_DFLT;
        if (u == 8'h46) begin
            consume();
            tok(k, cctr_pkg::S_FLOAT, 1'b0);
        end else if (u == 8'h4c) begin
            consume();
            tok(k, cctr_pkg::S_LDBL, 1'b0);
        end else tok(k, cctr_pkg::S_DOUBLE, 1'b0);
    endfunction

    function automatic void start_exp();
        if (!o_s.flags[cctr_pkg::F_MANT]) reject();
        else begin
            consume();
            o_s.phase = cctr_pkg::PH_EXPS;
        end
    endfunction

    function automatic void to_frac();
        consume();
        o_s.flags[cctr_pkg::F_POINT] = 1'b1;
        o_s.phase = cctr_pkg::PH_FRAC;
    endfunction

endmodule

// File: sv/cctr_start.sv
// ----------------------------------------------------------------------------
// cctr_start: token start decode
// Opens a fresh scan state from the first character of a token.
// ----------------------------------------------------------------------------
module cctr_start (
    input  logic [7:0]      i_c,
    output cctr_pkg::t_scan o_s,
    output logic            o_emit
);
    always_comb begin
        o_s = '0;
        o_s.phase = cctr_pkg::PH_DONE;
        o_s.len   = 8'd1;
        o_emit    = 1'b0;
        if (i_c == 8'h4c) begin
            o_s.flags[cctr_pkg::F_WIDE] = 1'b1;
            o_s.phase = cctr_pkg::PH_CHL;
        end else if (i_c == 8'h27) begin
            o_s.phase = cctr_pkg::PH_CHBODY;
        end else if (cctr_pkg::is_dig(i_c)) begin
            o_s.digits = 8'd1;
            o_s.flags[cctr_pkg::F_MANT] = 1'b1;
            o_s.phase = (i_c == 8'h30) ? cctr_pkg::PH_ZERO : cctr_pkg::PH_DEC;
        end else if (i_c == 8'h2e) begin
            o_s.flags[cctr_pkg::F_POINT] = 1'b1;
            o_s.phase = cctr_pkg::PH_FRAC;
        end else begin
            // cannot begin a constant: reject at once
            o_s.len = 8'd0;
            o_emit  = 1'b1;
        end
    end
endmodule

// File: sv/cctr_outq.sv
// ----------------------------------------------------------------------------
// cctr_outq: result queue
// Four-entry FIFO of result records; the producer checks room for two.
// ----------------------------------------------------------------------------
module cctr_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_push_n,
    input  cctr_pkg::t_res i_d0,
    input  logic           i_l0,
    input  cctr_pkg::t_res i_d1,
    output logic           o_room2,
    output logic           o_valid,
    output cctr_pkg::t_res o_d,
    output logic           o_last,
    input  logic           i_ready
);
    // entry: result record plus last flag
    logic [17:0] r_mem [4];
    logic [1:0]  r_rp, r_wp, n_rp, n_wp;
    logic [2:0]  r_cnt, n_cnt;
    logic        pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = r_cnt != 3'd0;
    assign {o_d, o_last} = r_mem[r_rp];
    assign o_room2 = (r_cnt - {2'b0, pop}) <= 3'd2;

    always_comb begin
        n_rp  = r_rp + {1'b0, pop};
        n_wp  = r_wp + i_push_n;
        n_cnt = r_cnt + {1'b0, i_push_n} - {2'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) r_mem[r_wp] <= {i_d0, i_l0};
        if (i_push_n == 2'd2) r_mem[r_wp + 2'd1] <= {i_d1, 1'b1};
        if (!i_rst_n) begin
            r_rp  <= '0;
            r_wp  <= '0;
            r_cnt <= '0;
        end else begin
            r_rp  <= n_rp;
            r_wp  <= n_wp;
            r_cnt <= n_cnt;
        end
    end
endmodule

// File: sv/c_constant_token_recognizer.sv
// Output: a decided result is registered in the result queue.
// Throughput: one character per cycle while o_ready is high; the scan state
// loop is one logic step; a four-entry result queue decouples the output side.
// Reset: synchronous active low; scanner idle, result queue empty.
// ----------------------------------------------------------------------------
// c_constant_token_recognizer: C99 constant recognizer, one byte per request
// ----------------------------------------------------------------------------
module c_constant_token_recognizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_first,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_match_length,
    output logic [2:0] o_kind,
    output logic [3:0] o_suffix_type,
    output logic       o_long_digits,
    output logic       o_length_saturated,
    output logic       o_last
);
    cctr_pkg::t_scan r_s, n_s, st_s, sp_s;
    cctr_pkg::t_res  st_res, r0, r1, qd;
    logic            st_emit, sp_emit, pend, acc, room2;
    logic [1:0]      npush;

    assign pend = r_s.phase != cctr_pkg::PH_IDLE && r_s.phase != cctr_pkg::PH_DONE;
    assign o_ready = room2;
    assign acc = i_valid && o_ready;

    cctr_step u_step (
        .i_s(r_s), .i_c(i_first ? 8'h00 : i_ch), .o_s(st_s),
        .o_emit(st_emit), .o_res(st_res)
    );
    cctr_start u_start (.i_c(i_ch), .o_s(sp_s), .o_emit(sp_emit));

    // Combine flush of the pending token with the new start
    always_comb begin
        n_s   = r_s;
        npush = 2'd0;
        r0    = st_res;
        r1    = '0;
        if (acc) begin
            if (i_first) begin
                n_s = sp_s;
                if (pend && sp_emit) begin
                    npush = 2'd2;
                end else if (pend) begin
                    npush = 2'd1;
                end else if (sp_emit) begin
                    npush = 2'd1;
                    r0 = '0;
                end
            end else begin
                n_s = st_s;
                npush = {1'b0, st_emit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '{phase: cctr_pkg::PH_IDLE, len: 8'd0, digits: 8'd0,
                     flags: 7'd0, sfc: 8'd0, esc: 1'b0};
        end else begin
            r_s <= n_s;
        end
    end

    cctr_outq u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push_n(npush), .i_d0(r0),
        .i_l0(npush == 2'd1), .i_d1(r1), .o_room2(room2), .o_valid(o_valid),
        .o_d(qd), .o_last(o_last), .i_ready(i_ready)
    );

    assign o_match_length     = qd.len;
    assign o_kind             = qd.kind;
    assign o_suffix_type      = qd.suf;
    assign o_long_digits      = qd.ld;
    assign o_length_saturated = qd.sat;
endmodule
